[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion helper macros used by the top-level design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, no reset qualifier
`define ASSERT_NEXT_CYCLE(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/fdc_pkg.sv]
// ---------------------------------------------------------------------------
// fdc_pkg
// types, codes and helper functions of the frame deframer with crc-8 check
// ---------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

   localparam int unsigned HEADER_BYTES = 16;
   localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'hAB;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_WORD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_FLAG_MASK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_ENDIAN    = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DROP    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_PAYLOAD   = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_BAD_MAGIC = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       chunk_end;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  payload_byte;
      logic        frame_last;
      logic [15:0] sequence_res;
      logic [15:0] flags;
      logic [31:0] timestamp;
      logic [15:0] payload_length;
      logic        crc_ok;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] magic_word;
      logic [15:0] crc_flag_mask;
      logic        big_endian;
   } cfg_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } in_stage_type;

   // reflected crc-8, one byte per call
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] hdr16(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic be);
      return be ? {b0, b1} : {b1, b0};
   endfunction

   function automatic logic [31:0] hdr32(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic be);
      return be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
   endfunction

endpackage

`default_nettype wire

[design/fdc_chan_if.sv]
// ---------------------------------------------------------------------------
// fdc_chan_if
// valid/ready channel carrying one payload item per transfer
// ---------------------------------------------------------------------------
`default_nettype none

interface fdc_chan_if #(
   parameter type payload_type = logic [7:0]
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[design/fdc_csr.sv]
// ---------------------------------------------------------------------------
// fdc_csr
// configuration registers written through the plain write port
// ---------------------------------------------------------------------------
`default_nettype none

module fdc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [fdc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [fdc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output fdc_pkg::cfg_type                          cfg
);

   fdc_pkg::cfg_type cfg_ff;
   fdc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            fdc_pkg::CSR_MAGIC_WORD:    cfg_in.magic_word    = csr_wdata;
            fdc_pkg::CSR_CRC_FLAG_MASK: cfg_in.crc_flag_mask = csr_wdata;
            fdc_pkg::CSR_BIG_ENDIAN:    cfg_in.big_endian    = csr_wdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word    <= 16'h0000;
         cfg_ff.crc_flag_mask <= 16'h0001;
         cfg_ff.big_endian    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/fdc_in_stage.sv]
// ---------------------------------------------------------------------------
// fdc_in_stage
// input register holding one received byte until the core takes it
// ---------------------------------------------------------------------------
`default_nettype none

module fdc_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   fdc_chan_if.sink               req_if,
   input  wire logic              advance,
   output fdc_pkg::in_stage_type  stage
);

   logic                  valid_ff;
   logic                  valid_in;
   fdc_pkg::req_item_type item_ff;
   logic                  take;

   // the register frees up in the same cycle the core consumes it
   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_if.payload;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

[design/fdc_core.sv]
// ---------------------------------------------------------------------------
// fdc_core
// header collection, payload pass-through, crc-8 check and result register
// ---------------------------------------------------------------------------
`default_nettype none

module fdc_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fdc_pkg::cfg_type       cfg,
   input  wire fdc_pkg::in_stage_type  stage,
   output logic                        advance,
   fdc_chan_if.source                  rsp_if
);

   localparam int unsigned IDX_W = fdc_pkg::HDR_IDX_W;
   localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(fdc_pkg::HEADER_BYTES - 1);

   fdc_pkg::phase_type    phase_ff, phase_in;
   logic [IDX_W-1:0]      count_ff, count_in;
   logic [15:0]           left_ff, left_in;
   logic [7:0]            crc_ff, crc_in;
   logic [7:0]            hdr_store_ff [fdc_pkg::HEADER_BYTES];

   logic                  out_valid_ff, out_valid_in;
   fdc_pkg::rsp_item_type out_data_ff;

   logic                  res_valid;
   fdc_pkg::rsp_item_type res;

   logic [7:0]            data_byte;
   logic                  chunk_end;
   logic [15:0]           hdr_magic, hdr_flags, hdr_seq, hdr_len;
   logic [31:0]           hdr_ts;
   logic                  crc_flagged;
   logic [7:0]            crc_next;
   logic [15:0]           left_dec;
   logic                  hdr_done;

   assign data_byte = stage.item.byte_in;
   assign chunk_end = stage.item.chunk_end;

   // process the held byte when the result register is free or draining
   assign advance = stage.valid && (!out_valid_ff || rsp_if.ready);

   assign hdr_magic = fdc_pkg::hdr16(hdr_store_ff[0], hdr_store_ff[1], cfg.big_endian);
   assign hdr_flags = fdc_pkg::hdr16(hdr_store_ff[2], hdr_store_ff[3], cfg.big_endian);
   assign hdr_ts    = fdc_pkg::hdr32(hdr_store_ff[4], hdr_store_ff[5], hdr_store_ff[6],
                                     hdr_store_ff[7], cfg.big_endian);
   assign hdr_seq   = fdc_pkg::hdr16(hdr_store_ff[8], hdr_store_ff[9], cfg.big_endian);
   assign hdr_len   = fdc_pkg::hdr16(hdr_store_ff[10], hdr_store_ff[11], cfg.big_endian);

   assign crc_flagged = (hdr_flags & cfg.crc_flag_mask) != 16'h0000;
   assign crc_next    = fdc_pkg::crc8_next(crc_ff, data_byte);
   assign left_dec    = left_ff - 16'd1;
   assign hdr_done    = (count_ff == HDR_LAST);

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      left_in  = left_ff;
      crc_in   = crc_ff;
      if (advance) begin
         unique case (phase_ff)
            fdc_pkg::PH_HEADER: begin
               if (hdr_done) begin
                  count_in = '0;
                  if (hdr_magic != cfg.magic_word) begin
                     phase_in = chunk_end ? fdc_pkg::PH_HEADER : fdc_pkg::PH_DROP;
                  end else begin
                     crc_in  = fdc_pkg::CRC_INIT;
                     left_in = hdr_len;
                     phase_in = (hdr_len == 16'h0000) ? fdc_pkg::PH_HEADER
                                                      : fdc_pkg::PH_PAYLOAD;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            fdc_pkg::PH_PAYLOAD: begin
               crc_in  = crc_next;
               left_in = left_dec;
               if (left_dec == 16'h0000) begin
                  phase_in = fdc_pkg::PH_HEADER;
                  count_in = '0;
               end
            end
            fdc_pkg::PH_DROP: begin
               if (chunk_end) begin
                  phase_in = fdc_pkg::PH_HEADER;
                  count_in = '0;
               end
            end
            default: begin
               phase_in = fdc_pkg::PH_HEADER;
               count_in = '0;
            end
         endcase
      end
   end

   // result of the byte being processed
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      unique case (phase_ff)
         fdc_pkg::PH_HEADER: begin
            if (hdr_done) begin
               if (hdr_magic != cfg.magic_word) begin
                  res_valid  = 1'b1;
                  res.status = fdc_pkg::STATUS_BAD_MAGIC;
               end else if (hdr_len == 16'h0000) begin
                  res_valid          = 1'b1;
                  res.status         = fdc_pkg::STATUS_EMPTY;
                  res.frame_last     = 1'b1;
                  res.sequence_res   = hdr_seq;
                  res.flags          = hdr_flags;
                  res.timestamp      = hdr_ts;
                  res.payload_length = hdr_len;
                  res.crc_ok = !crc_flagged || (fdc_pkg::CRC_INIT == hdr_store_ff[12]);
               end
            end
         end
         fdc_pkg::PH_PAYLOAD: begin
            res_valid          = 1'b1;
            res.status         = fdc_pkg::STATUS_PAYLOAD;
            res.payload_byte   = data_byte;
            res.sequence_res   = hdr_seq;
            res.flags          = hdr_flags;
            res.timestamp      = hdr_ts;
            res.payload_length = hdr_len;
            if (left_dec == 16'h0000) begin
               res.frame_last = 1'b1;
               res.crc_ok     = !crc_flagged || (crc_next == hdr_store_ff[12]);
            end
         end
         fdc_pkg::PH_DROP: begin
            res_valid = 1'b0;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (advance) begin
         out_valid_in = res_valid;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fdc_pkg::PH_HEADER;
         count_ff     <= '0;
         left_ff      <= 16'h0000;
         crc_ff       <= fdc_pkg::CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && (phase_ff == fdc_pkg::PH_HEADER)) begin
         hdr_store_ff[count_ff] <= data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

endmodule

`default_nettype wire

[design/frame_deframer_crc8_check.sv]
// ---------------------------------------------------------------------------
// frame_deframer_crc8_check
// length-prefixed frame deframer with crc-8 payload check
// ---------------------------------------------------------------------------
// usage:
//   req_if takes one stream byte per transfer with a chunk_end marker.
//   rsp_if gives at most one result per byte: a payload byte with the
//   decoded header fields, an empty-frame result, or a bad-magic result.
//   dropped bytes and all header bytes but the last give no result.
//   csr_we/csr_index/csr_wdata write magic_word, crc_flag_mask, big_endian;
//   write them only while the block is idle.
// path: a byte is held in the input register, then its result is
//   registered in the result register.
// throughput: one byte per cycle while rsp_if.ready holds high, set by
//   the single processing stage between the input and result registers.
// reset: synchronous; header collection restarts and both registers empty.
// stall: while rsp_if.ready is low a waiting result holds, the input
//   register still takes one more byte, then req_if.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module frame_deframer_crc8_check (
   input  wire logic                            clock,
   input  wire logic                            reset,
   fdc_chan_if.sink                             req_if,
   fdc_chan_if.source                           rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [fdc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fdc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fdc_pkg::cfg_type      cfg;
   fdc_pkg::in_stage_type stage;
   logic                  advance;

   fdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fdc_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .advance (advance),
      .stage   (stage)
   );

   fdc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .stage   (stage),
      .advance (advance),
      .rsp_if  (rsp_if)
   );

   `ASSERT_NEXT_CYCLE(a_reset_empties_output, clock, reset, !rsp_if.valid,
      "result valid right after reset")

   `ASSERT_SAME_CYCLE(a_non_payload_zero_byte, clock, reset,
      rsp_if.valid && (rsp_if.payload.status != fdc_pkg::STATUS_PAYLOAD),
      rsp_if.payload.payload_byte == 8'h00,
      "payload byte set on a non-payload result")

   `ASSERT_SAME_CYCLE(a_bad_magic_clean, clock, reset,
      rsp_if.valid && (rsp_if.payload.status == fdc_pkg::STATUS_BAD_MAGIC),
      !rsp_if.payload.frame_last && !rsp_if.payload.crc_ok &&
      (rsp_if.payload.payload_length == 16'h0000),
      "bad magic result carries frame data")

   `ASSERT_SAME_CYCLE(a_crc_ok_only_last, clock, reset,
      rsp_if.valid && !rsp_if.payload.frame_last,
      !rsp_if.payload.crc_ok,
      "crc verdict on a byte that does not end a frame")

   `ASSERT_SAME_CYCLE(a_empty_is_last, clock, reset,
      rsp_if.valid && (rsp_if.payload.status == fdc_pkg::STATUS_EMPTY),
      rsp_if.payload.frame_last && (rsp_if.payload.payload_length == 16'h0000),
      "empty frame result malformed")

endmodule

`default_nettype wire

[tb/tb_frame_deframer_crc8_check.sv]
// ---------------------------------------------------------------------------
// tb_frame_deframer_crc8_check
// Drives a byte stream of framed, broken and noisy traffic into the deframer.
// A scoreboard class predicts the result of each byte transfer from its own
// copy of the header, crc and register state. It compares every result
// transfer field by field, in order. Both channels stall at random rates,
// and the registers are rewritten between phases while nothing is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_frame_deframer_crc8_check;

   import fdc_pkg::*;

   localparam int         HDR_LEN        = 16;
   localparam logic [7:0] CRC_SEED       = 8'hFF;
   localparam logic [7:0] CRC_POLY_REFL  = 8'hAB;
   localparam int         WATCHDOG_LIMIT = 2000;

   class deframe_scoreboard;
      logic [15:0]  magic_word    = 16'h0000;
      logic [15:0]  crc_flag_mask = 16'h0001;
      logic         big_endian    = 1'b1;
      phase_type    phase         = PH_HEADER;
      int           hdr_count     = 0;
      logic [7:0]   hdr [HDR_LEN];
      logic [15:0]  bytes_left    = 16'd0;
      logic [7:0]   crc_acc       = CRC_SEED;
      rsp_item_type pending [$];
      int           errors        = 0;

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_MAGIC_WORD:    magic_word = val;
            CSR_CRC_FLAG_MASK: crc_flag_mask = val;
            CSR_BIG_ENDIAN:    big_endian = val[0];
            default: ;
         endcase
      endfunction

      // reflected crc, fed one data bit at a time, lsb first
      function logic [7:0] crc_step(logic [7:0] c, logic [7:0] d);
         logic fb;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY_REFL;
         end
         return c;
      endfunction

      function logic [15:0] word_at(int pos);
         return big_endian ? {hdr[pos], hdr[pos+1]} : {hdr[pos+1], hdr[pos]};
      endfunction

      function rsp_item_type header_fields();
         rsp_item_type r;
         r = '0;
         r.sequence_res   = word_at(8);
         r.flags          = word_at(2);
         r.timestamp      = big_endian ? {hdr[4], hdr[5], hdr[6], hdr[7]}
                                       : {hdr[7], hdr[6], hdr[5], hdr[4]};
         r.payload_length = word_at(10);
         return r;
      endfunction

      function logic crc_result(logic [7:0] c);
         if ((word_at(2) & crc_flag_mask) == 16'd0) return 1'b1;
         return c == hdr[12];
      endfunction

      function bit aligned();
         return phase == PH_HEADER && hdr_count == 0;
      endfunction

      function void note_byte(req_item_type it);
         rsp_item_type r;
         r = '0;
         case (phase)
            PH_DROP: begin
               if (it.chunk_end) begin
                  phase     = PH_HEADER;
                  hdr_count = 0;
               end
            end
            PH_PAYLOAD: begin
               crc_acc        = crc_step(crc_acc, it.byte_in);
               bytes_left     = bytes_left - 16'd1;
               r              = header_fields();
               r.status       = STATUS_PAYLOAD;
               r.payload_byte = it.byte_in;
               if (bytes_left == 16'd0) begin
                  r.frame_last = 1'b1;
                  r.crc_ok     = crc_result(crc_acc);
                  phase        = PH_HEADER;
                  hdr_count    = 0;
               end
               pending.push_back(r);
            end
            default: begin
               hdr[hdr_count] = it.byte_in;
               hdr_count++;
               if (hdr_count == HDR_LEN) begin
                  hdr_count = 0;
                  if (word_at(0) != magic_word) begin
                     r.status = STATUS_BAD_MAGIC;
                     phase    = it.chunk_end ? PH_HEADER : PH_DROP;
                     pending.push_back(r);
                  end else begin
                     bytes_left = word_at(10);
                     crc_acc    = CRC_SEED;
                     if (bytes_left == 16'd0) begin
                        r            = header_fields();
                        r.status     = STATUS_EMPTY;
                        r.frame_last = 1'b1;
                        r.crc_ok     = crc_result(CRC_SEED);
                        pending.push_back(r);
                     end else begin
                        phase = PH_PAYLOAD;
                     end
                  end
               end
            end
         endcase
      endfunction

      function void match(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: status %0d, payload_byte %0h",
                   got.status, got.payload_byte);
            errors++;
            return;
         end
         want = pending.pop_front();
         match("status", want.status, got.status);
         match("payload_byte", want.payload_byte, got.payload_byte);
         match("frame_last", want.frame_last, got.frame_last);
         match("sequence_res", want.sequence_res, got.sequence_res);
         match("flags", want.flags, got.flags);
         match("timestamp", want.timestamp, got.timestamp);
         match("payload_length", want.payload_length, got.payload_length);
         match("crc_ok", want.crc_ok, got.crc_ok);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   fdc_chan_if #(.payload_type(req_item_type)) req_if ();
   fdc_chan_if #(.payload_type(rsp_item_type)) rsp_if ();

   frame_deframer_crc8_check uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   deframe_scoreboard sb;
   int src_idle_pct = 31;
   int rsp_idle_pct = 86;
   int sent_count   = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_byte(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic logic [15:0] order16(input logic [15:0] v);
      return sb.big_endian ? v : {v[7:0], v[15:8]};
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] b, input logic ce);
      req_item_type it;
      it.byte_in   = b;
      it.chunk_end = ce;
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic set_config(input logic [15:0] magic, input logic [15:0] mask,
                             input logic be);
      write_csr(CSR_MAGIC_WORD, magic);
      write_csr(CSR_CRC_FLAG_MASK, mask);
      write_csr(CSR_BIG_ENDIAN, {15'd0, be});
      csr_we <= 1'b0;
   endtask

   // stop sending and let every byte in flight come out
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // keep < 0 sends the whole frame, otherwise at most its first keep bytes
   task automatic send_frame(input logic [15:0] magic, input logic [15:0] flags,
                             input logic [31:0] stamp, input logic [15:0] seq,
                             input logic [15:0] len, input bit crc_good,
                             input int cend_pct, input bit mark_hdr_end, input int keep);
      logic [7:0]   body [$];
      logic [7:0]   crc;
      logic [31:0]  stamp_wire;
      logic [127:0] hdr;
      int           total;
      crc = CRC_SEED;
      for (int i = 0; i < int'(len); i++) begin
         body.push_back(8'($urandom));
         crc = sb.crc_step(crc, body[i]);
      end
      if (!crc_good) crc = crc ^ 8'($urandom_range(255, 1));
      stamp_wire = sb.big_endian ? stamp
                                 : {stamp[7:0], stamp[15:8], stamp[23:16], stamp[31:24]};
      hdr = {order16(magic), order16(flags), stamp_wire, order16(seq), order16(len),
             crc, 24'($urandom)};
      total = HDR_LEN + int'(len);
      if (keep >= 0 && keep < total) total = keep;
      for (int i = 0; i < total; i++)
         send_byte(i < HDR_LEN ? hdr[127 - 8*i -: 8] : body[i - HDR_LEN],
                   ($urandom_range(99) < cend_pct) || (mark_hdr_end && i == HDR_LEN - 1));
   endtask

   // bring the deframer back to the start of a header
   task automatic realign();
      while (!sb.aligned()) begin
         if (sb.phase == PH_DROP)
            send_byte(8'($urandom), $urandom_range(3) == 0);
         else if (sb.phase == PH_PAYLOAD)
            send_byte(8'($urandom), $urandom_range(9) == 0);
         else
            // zero fill keeps a cut header's length small
            send_byte(8'h00, $urandom_range(9) == 0);
      end
   endtask

   task automatic random_frame();
      int          pick;
      int          n;
      logic [15:0] len;
      logic [15:0] flags;
      logic [7:0]  b;
      logic [7:0]  lead;
      realign();
      pick = $urandom_range(99);
      n    = $urandom_range(99);
      len  = (n < 20) ? 16'd0 : (n < 90) ? 16'($urandom_range(12, 1))
                                         : 16'($urandom_range(64, 13));
      flags = 16'($urandom);
      if ($urandom_range(1) == 1) flags = flags | sb.crc_flag_mask;
      else flags = flags & ~sb.crc_flag_mask;
      if (pick < 68) begin
         send_frame(sb.magic_word, flags, $urandom, 16'($urandom), len,
                    $urandom_range(3) != 0, 4, 1'b0, -1);
      end else if (pick < 80) begin
         // wrong magic, header only; the drop is ended by realign
         send_frame(sb.magic_word ^ 16'($urandom_range(65535, 1)), flags, $urandom,
                    16'($urandom), len, 1'b1, 4, $urandom_range(9) < 4, HDR_LEN);
      end else if (pick < 90) begin
         // noise never starts a header with a matching first magic byte
         lead = sb.big_endian ? sb.magic_word[15:8] : sb.magic_word[7:0];
         repeat ($urandom_range(24, 1)) begin
            b = 8'($urandom);
            if (sb.aligned() && b == lead) b = ~b;
            send_byte(b, $urandom_range(9) == 0);
         end
      end else begin
         send_frame(sb.magic_word, flags, $urandom, 16'($urandom), len, 1'b1, 4, 1'b0,
                    $urandom_range(HDR_LEN + int'(len) - 1, 1));
      end
   endtask

   initial begin
      int base;
      sb             = new();
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      set_config(16'hA55A, 16'h0001, 1'b1);
      // empty frames: crc flagged and matching, then flagged and wrong
      send_frame(16'hA55A, 16'h0001, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 1'b1, 0, 1'b0, -1);
      send_frame(16'hA55A, 16'hFFFF, 32'h0000_0000, 16'h0000, 16'd0, 1'b0, 0, 1'b0, -1);
      // bad magic ending a chunk restarts collection at once
      send_frame(16'h245B, 16'h0000, 32'h0, 16'h0, 16'd0, 1'b1, 0, 1'b1, -1);
      // chunk ends inside header and payload change nothing; crc not flagged
      send_frame(16'hA55A, 16'h0000, 32'h8000_0001, 16'h1234, 16'd1, 1'b0, 100, 1'b0, -1);
      // bad magic, bytes dropped up to the chunk end
      send_frame(16'hA55B, 16'h0001, 32'h0, 16'h0, 16'd4, 1'b1, 0, 1'b0, HDR_LEN);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_frame(16'hA55A, 16'h0001, 32'h0102_0304, 16'h0506, 16'd3, 1'b1, 0, 1'b0, -1);
      send_frame(16'hA55A, 16'h8000, 32'hFFFF_0000, 16'h7FFF, 16'd2, 1'b0, 0, 1'b0, -1);

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         src_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 86 : 0;
         rsp_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 31 : 0;
         case (ph)
            0: set_config(16'h0000, 16'hFFFF, 1'b0);
            1: set_config(16'hFFFF, 16'h0000, 1'b1);
            2: set_config(16'($urandom), 16'h0001 << $urandom_range(15), 1'b0);
            3: set_config(16'($urandom), 16'($urandom), 1'b1);
            4: set_config(16'hFFFF, 16'hFFFF, 1'b0);
            default: set_config(16'($urandom), 16'h0001, 1'b1);
         endcase
         base = sent_count;
         while (sent_count - base < 220) random_frame();
      end

      settle();
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
